// ===== hw/rtl/btafc_pkg.sv =====
// ----------------------------------------------------------------------------
// btafc_pkg
// Shared types and constants for the bare TCP ACK frame classifier.
// ----------------------------------------------------------------------------
package btafc_pkg;

  localparam int unsigned PosW = 7;

  localparam logic [PosW-1:0] POS_MAX      = 7'd127;
  localparam logic [PosW-1:0] POS_OUTER_HI = 7'd12;
  localparam logic [PosW-1:0] POS_OUTER_LO = 7'd13;
  localparam logic [PosW-1:0] POS_INNER_HI = 7'd16;
  localparam logic [PosW-1:0] POS_INNER_LO = 7'd17;
  localparam logic [PosW-1:0] POS_PPP_HI   = 7'd20;
  localparam logic [PosW-1:0] POS_PPP_LO   = 7'd21;
  localparam logic [PosW-1:0] POS_TPPP_HI  = 7'd24;
  localparam logic [PosW-1:0] POS_TPPP_LO  = 7'd25;

  localparam logic [4:0] IP_OFF_NONE   = 5'd0;
  localparam logic [4:0] IP_OFF_PLAIN  = 5'd14;
  localparam logic [4:0] IP_OFF_TAGGED = 5'd18;
  localparam logic [4:0] IP_OFF_PPPOE  = 5'd22;
  localparam logic [4:0] IP_OFF_TPPPOE = 5'd26;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_PPPD = 16'h8863;
  localparam logic [15:0] ETH_PPPS = 16'h8864;
  localparam logic [15:0] PPP_IPV4 = 16'h0021;

  localparam logic [7:0] IP_PROTO_TCP = 8'd6;

  // IP and TCP header relative byte indexes
  localparam logic [PosW-1:0] IP_R_VIHL  = 7'd0;
  localparam logic [PosW-1:0] IP_R_LENHI = 7'd2;
  localparam logic [PosW-1:0] IP_R_LENLO = 7'd3;
  localparam logic [PosW-1:0] IP_R_PROTO = 7'd9;
  localparam logic [PosW-1:0] TCP_R_OFF  = 7'd12;
  localparam logic [PosW-1:0] TCP_R_FLAG = 7'd13;

  localparam logic [2:0] ENC_NONE   = 3'd0;
  localparam logic [2:0] ENC_PLAIN  = 3'd1;
  localparam logic [2:0] ENC_TAGGED = 3'd2;
  localparam logic [2:0] ENC_PPPOE  = 3'd3;
  localparam logic [2:0] ENC_TPPPOE = 3'd4;

  typedef struct packed {
    logic       bare_ack;
    logic [2:0] encapsulation;
  } btafc_result_t;

  function automatic logic [2:0] enc_of_offset(input logic [4:0] off);
    logic [2:0] enc;
    unique case (off)
      IP_OFF_PLAIN:  enc = ENC_PLAIN;
      IP_OFF_TAGGED: enc = ENC_TAGGED;
      IP_OFF_PPPOE:  enc = ENC_PPPOE;
      IP_OFF_TPPPOE: enc = ENC_TPPPOE;
      default:       enc = ENC_NONE;
    endcase
    return enc;
  endfunction

  function automatic logic is_pppoe(input logic [15:0] t);
    return (t == ETH_PPPD) || (t == ETH_PPPS);
  endfunction

endpackage

// ===== hw/rtl/btafc_if.sv =====
// ----------------------------------------------------------------------------
// btafc_if
// Valid/ready channels for frame bytes and classification results.
// ----------------------------------------------------------------------------
interface btafc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface btafc_out_if;
  logic       valid;
  logic       ready;
  logic       bare_ack;
  logic [2:0] encapsulation;

  modport source (output valid, output bare_ack, output encapsulation, input ready);
  modport sink   (input valid, input bare_ack, input encapsulation, output ready);
endinterface

// ===== hw/rtl/btafc_frame_parser.sv =====
// ----------------------------------------------------------------------------
// btafc_frame_parser
// Per-frame header state; consumes one byte per step and gives the
// classification that holds once the current byte is taken.
// ----------------------------------------------------------------------------
module btafc_frame_parser
  import btafc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [7:0]    frame_byte_i,
  input  logic          end_of_frame_i,
  input  logic          require_ack_i,
  output btafc_result_t result_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     outer_q, outer_d;
  logic [15:0]     inner_q, inner_d;
  logic [15:0]     ppp_q, ppp_d;
  logic [4:0]      ip_off_q, ip_off_d;
  logic [3:0]      hdr_words_q, hdr_words_d;
  logic [15:0]     total_len_q, total_len_d;
  logic            is_tcp_q, is_tcp_d;
  logic [3:0]      tcp_words_q, tcp_words_d;
  logic            ack_q, ack_d;
  logic            tcp_seen_q, tcp_seen_d;

  logic [PosW-1:0] rel;
  logic [PosW-1:0] hdr_bytes;
  logic [PosW-1:0] hdr_sum;
  logic [2:0]      enc;
  logic            no_payload;

  always_comb begin
    pos_d       = pos_q;
    outer_d     = outer_q;
    inner_d     = inner_q;
    ppp_d       = ppp_q;
    ip_off_d    = ip_off_q;
    hdr_words_d = hdr_words_q;
    total_len_d = total_len_q;
    is_tcp_d    = is_tcp_q;
    tcp_words_d = tcp_words_q;
    ack_d       = ack_q;
    tcp_seen_d  = tcp_seen_q;
    rel         = pos_q - {2'b00, ip_off_q};
    hdr_bytes   = {1'b0, hdr_words_q, 2'b00};

    if (pos_q != POS_MAX) begin
      pos_d = pos_q + 7'd1;
      if (pos_q == POS_OUTER_HI) outer_d = {frame_byte_i, 8'h00};
      if (pos_q == POS_OUTER_LO) begin
        outer_d = {outer_q[15:8], frame_byte_i};
        if (outer_d == ETH_IPV4) ip_off_d = IP_OFF_PLAIN;
      end
      if (outer_d == ETH_VLAN) begin
        if (pos_q == POS_INNER_HI) inner_d = {frame_byte_i, 8'h00};
        if (pos_q == POS_INNER_LO) begin
          inner_d = {inner_q[15:8], frame_byte_i};
          if (inner_d == ETH_IPV4 && ip_off_q == IP_OFF_NONE) ip_off_d = IP_OFF_TAGGED;
        end
        if (pos_q == POS_TPPP_HI) ppp_d = {frame_byte_i, 8'h00};
        if (pos_q == POS_TPPP_LO) begin
          ppp_d = {ppp_q[15:8], frame_byte_i};
          if (is_pppoe(inner_q) && ppp_d == PPP_IPV4 && ip_off_q == IP_OFF_NONE)
            ip_off_d = IP_OFF_TPPPOE;
        end
      end else if (is_pppoe(outer_d)) begin
        if (pos_q == POS_PPP_HI) ppp_d = {frame_byte_i, 8'h00};
        if (pos_q == POS_PPP_LO) begin
          ppp_d = {ppp_q[15:8], frame_byte_i};
          if (ppp_d == PPP_IPV4 && ip_off_q == IP_OFF_NONE) ip_off_d = IP_OFF_PPPOE;
        end
      end

      // new offsets are always set before the header starts, so the old one serves
      if (ip_off_q != IP_OFF_NONE && pos_q >= {2'b00, ip_off_q}) begin
        if (rel == IP_R_VIHL)  hdr_words_d = frame_byte_i[3:0];
        if (rel == IP_R_LENHI) total_len_d = {frame_byte_i, 8'h00};
        if (rel == IP_R_LENLO) total_len_d = {total_len_q[15:8], frame_byte_i};
        if (rel == IP_R_PROTO) is_tcp_d = (frame_byte_i == IP_PROTO_TCP);
        if (rel == hdr_bytes + TCP_R_OFF) tcp_words_d = frame_byte_i[7:4];
        if (rel == hdr_bytes + TCP_R_FLAG) begin
          ack_d      = frame_byte_i[4];
          tcp_seen_d = 1'b1;
        end
      end
    end

    hdr_sum    = {1'b0, tcp_words_d, 2'b00} + {1'b0, hdr_words_d, 2'b00};
    enc        = enc_of_offset(ip_off_d);
    no_payload = (total_len_d == {9'd0, hdr_sum});

    result_o.encapsulation = enc;
    result_o.bare_ack      = (enc != ENC_NONE) && is_tcp_d && tcp_seen_d && no_payload &&
                             (!require_ack_i || ack_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      outer_q     <= '0;
      inner_q     <= '0;
      ppp_q       <= '0;
      ip_off_q    <= IP_OFF_NONE;
      hdr_words_q <= '0;
      total_len_q <= '0;
      is_tcp_q    <= 1'b0;
      tcp_words_q <= '0;
      ack_q       <= 1'b0;
      tcp_seen_q  <= 1'b0;
    end else if (step_i) begin
      if (end_of_frame_i) begin
        pos_q       <= '0;
        outer_q     <= '0;
        inner_q     <= '0;
        ppp_q       <= '0;
        ip_off_q    <= IP_OFF_NONE;
        hdr_words_q <= '0;
        total_len_q <= '0;
        is_tcp_q    <= 1'b0;
        tcp_words_q <= '0;
        ack_q       <= 1'b0;
        tcp_seen_q  <= 1'b0;
      end else begin
        pos_q       <= pos_d;
        outer_q     <= outer_d;
        inner_q     <= inner_d;
        ppp_q       <= ppp_d;
        ip_off_q    <= ip_off_d;
        hdr_words_q <= hdr_words_d;
        total_len_q <= total_len_d;
        is_tcp_q    <= is_tcp_d;
        tcp_words_q <= tcp_words_d;
        ack_q       <= ack_d;
        tcp_seen_q  <= tcp_seen_d;
      end
    end
  end

endmodule

// ===== hw/rtl/bare_tcp_ack_frame_classifier.sv =====
// ----------------------------------------------------------------------------
// bare_tcp_ack_frame_classifier
// Flags Ethernet frames that carry an IPv4 TCP segment with no payload.
//
//   channel  dir  payload                       transfer
//   in_i     in   frame_byte, end_of_frame      valid & ready
//   out_o    out  bare_ack, encapsulation       valid & ready
//   cfg      in   cfg_wdata_i (require ack)     cfg_we_i
//
// One byte per cycle while no last byte waits for the output register; the
// result is registered as the last byte leaves the input register. Only
// last-byte requests wait for the output register; other bytes never stall.
// Reset clears all frame state and sets require-ack to 1.
// ----------------------------------------------------------------------------
module bare_tcp_ack_frame_classifier
  import btafc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  btafc_in_if.sink     in_i,
  btafc_out_if.source  out_o
);

  logic          req_ack_q;
  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  logic          out_valid_q;
  btafc_result_t out_res_q;
  btafc_result_t res;
  logic          advance;
  logic          adv_last;

  assign adv_last    = in_valid_q && in_last_q && (!out_valid_q || out_o.ready);
  assign advance     = (in_valid_q && !in_last_q) || adv_last;
  assign in_i.ready  = !in_valid_q || advance;

  btafc_frame_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .frame_byte_i   (in_byte_q),
    .end_of_frame_i (in_last_q),
    .require_ack_i  (req_ack_q),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ack_q   <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) req_ack_q <= cfg_wdata_i;
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (adv_last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.frame_byte;
      in_last_q <= in_i.end_of_frame;
    end
    if (adv_last) out_res_q <= res;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.bare_ack      = out_res_q.bare_ack;
  assign out_o.encapsulation = out_res_q.encapsulation;

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv_last))
    else $error("result without a last byte");

  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_last_q)))
    else $error("input register lost a pending byte");

  a_bare_needs_ipv4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_res_q.bare_ack || out_res_q.encapsulation != ENC_NONE))
    else $error("bare ACK without IPv4");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !adv_last)
    else $error("pending result overwritten");

endmodule
